// ===== rtl/mvr_pkg.sv =====
// shared types, constants and functions of the mavlink v1 frame receiver
// checksum step, crc_extra table, controller command and status structs
// no dependencies
`default_nettype none

package mvr_pkg;

  // framing constants
  localparam logic [7:0]  SYNC_BYTE            = 8'hFE;
  localparam logic [15:0] CRC_SEED             = 16'hFFFF;
  localparam logic [8:0]  HEADER_BYTES         = 9'd4;
  localparam int          DEFAULT_BUFFER_DEPTH = 64;
  localparam int          EMIT_LIMIT           = 64;

  // per message id crc_extra byte
  localparam logic [7:0] CRC_EXTRA [256] = '{
    8'd50,  8'd124, 8'd137, 8'd0,   8'd237, 8'd217, 8'd104, 8'd119,
    8'd0,   8'd0,   8'd0,   8'd89,  8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd214, 8'd159, 8'd220, 8'd168,
    8'd24,  8'd23,  8'd170, 8'd144, 8'd67,  8'd115, 8'd39,  8'd246,
    8'd185, 8'd104, 8'd237, 8'd244, 8'd222, 8'd212, 8'd9,   8'd254,
    8'd230, 8'd28,  8'd28,  8'd132, 8'd221, 8'd232, 8'd11,  8'd153,
    8'd41,  8'd39,  8'd0,   8'd0,   8'd0,   8'd0,   8'd15,  8'd3,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd153, 8'd183, 8'd51,
    8'd82,  8'd118, 8'd148, 8'd21,  8'd0,   8'd243, 8'd124, 8'd0,
    8'd0,   8'd38,  8'd20,  8'd158, 8'd152, 8'd143, 8'd0,   8'd0,
    8'd0,   8'd106, 8'd49,  8'd22,  8'd29,  8'd12,  8'd241, 8'd233,
    8'd0,   8'd231, 8'd183, 8'd63,  8'd54,  8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd175, 8'd102, 8'd158, 8'd208,
    8'd56,  8'd93,  8'd211, 8'd108, 8'd32,  8'd185, 8'd84,  8'd0,
    8'd0,   8'd124, 8'd119, 8'd4,   8'd76,  8'd128, 8'd56,  8'd116,
    8'd134, 8'd237, 8'd203, 8'd250, 8'd87,  8'd203, 8'd220, 8'd25,
    8'd226, 8'd0,   8'd29,  8'd223, 8'd85,  8'd6,   8'd229, 8'd203,
    8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd42,  8'd49,  8'd0,   8'd134, 8'd219,
    8'd208, 8'd188, 8'd84,  8'd22,  8'd19,  8'd21,  8'd134, 8'd0,
    8'd78,  8'd68,  8'd189, 8'd127, 8'd154, 8'd21,  8'd21,  8'd144,
    8'd1,   8'd234, 8'd73,  8'd181, 8'd22,  8'd83,  8'd167, 8'd138,
    8'd234, 8'd240, 8'd47,  8'd189, 8'd52,  8'd174, 8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd8,   8'd204, 8'd49,  8'd170, 8'd44,  8'd83,  8'd46,  8'd0
  };

  // commands from controller to datapath
  typedef struct packed {
    logic load_len;   // length byte taken
    logic take_data;  // data byte taken
    logic take_cklo;  // low checksum byte taken
    logic clr_idx;    // good frame, start emitting
    logic rd_issue;   // read stored byte at emit index
    logic next_idx;   // emitted byte taken downstream
  } mvr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_sync;    // input byte is the start mark
    logic data_done;  // this data byte completes the frame body
    logic crc_match;  // input byte completes a matching checksum
    logic last_byte;  // byte on the output is the final one
  } mvr_sts_t;

  // one byte step of crc-16/mcrf4xx
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0] t;
    t = data ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mvr_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module mvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mvr_datapath.sv =====
// datapath of the frame receiver: counters, checksum, frame store, emit index
// depends on mvr_pkg and mvr_ram
`default_nettype none

module mvr_datapath #(
  parameter int BUFFER_DEPTH = mvr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       rx_byte,
  input  wire mvr_pkg::mvr_cmd_t cmd,
  output mvr_pkg::mvr_sts_t     sts,
  output logic      [7:0]       frame_byte,
  output logic      [5:0]       byte_index,
  output logic      [7:0]       message_id,
  output logic      [8:0]       frame_length,
  output logic                  truncated,
  output logic                  last
);

  localparam int AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int EMIT_LIM = (BUFFER_DEPTH < mvr_pkg::EMIT_LIMIT) ? BUFFER_DEPTH
                                                                  : mvr_pkg::EMIT_LIMIT;
  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);
  localparam logic [8:0] LIMIT9 = 9'(EMIT_LIM);

  logic [8:0]  expected_length;
  logic [8:0]  received_count;
  logic [8:0]  count_inc;
  logic [15:0] running_crc;
  logic [15:0] final_crc;
  logic [7:0]  checksum_low;
  logic [7:0]  extra_byte;
  logic [6:0]  emit_count;
  logic [5:0]  idx;
  logic        store_wr;

  assign count_inc = received_count + 9'd1;
  assign store_wr  = cmd.take_data && (received_count < DEPTH9);

  // frame length, byte count and running checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
      received_count  <= '0;
      running_crc     <= mvr_pkg::CRC_SEED;
    end else if (cmd.load_len) begin
      expected_length <= {1'b0, rx_byte} + mvr_pkg::HEADER_BYTES;
      received_count  <= '0;
      running_crc     <= mvr_pkg::crc_step(mvr_pkg::CRC_SEED, rx_byte);
    end else if (cmd.take_data) begin
      received_count  <= count_inc;
      running_crc     <= mvr_pkg::crc_step(running_crc, rx_byte);
    end
  end

  // message id and its crc_extra byte, taken from the fourth data byte
  always_ff @(posedge clk) begin
    if (cmd.take_data && (received_count == 9'd3)) begin
      message_id <= rx_byte;
      extra_byte <= mvr_pkg::CRC_EXTRA[rx_byte];
    end
  end

  // low checksum byte and emit bounds, known once the body is complete
  always_ff @(posedge clk) begin
    if (cmd.take_cklo) begin
      checksum_low <= rx_byte;
      emit_count   <= (received_count < LIMIT9) ? received_count[6:0] : LIMIT9[6:0];
      truncated    <= received_count > LIMIT9;
    end
  end

  // emit index and last marker
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.next_idx) begin
      idx <= idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      last <= ({1'b0, idx} + 7'd1) == emit_count;
    end
  end

  // frame store
  mvr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (store_wr),
    .wr_addr(AW'(received_count)),
    .wr_data(rx_byte),
    .rd_en  (cmd.rd_issue),
    .rd_addr(AW'(idx)),
    .rd_data(frame_byte)
  );

  // checksum compare with crc_extra folded in
  assign final_crc = mvr_pkg::crc_step(running_crc, extra_byte);

  assign sts.is_sync   = rx_byte == mvr_pkg::SYNC_BYTE;
  assign sts.data_done = count_inc == expected_length;
  assign sts.crc_match = final_crc == {rx_byte, checksum_low};
  assign sts.last_byte = last;

  assign byte_index   = idx;
  assign frame_length = received_count;

endmodule

`default_nettype wire

// ===== rtl/mvr_ctrl.sv =====
// controller state machine of the frame receiver
// depends on mvr_pkg
`default_nettype none

module mvr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire mvr_pkg::mvr_sts_t sts,
  output mvr_pkg::mvr_cmd_t      cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LEN  = 7'b0000010,
    ST_DATA = 7'b0000100,
    ST_CKLO = 7'b0001000,
    ST_CKHI = 7'b0010000,
    ST_READ = 7'b0100000,
    ST_SEND = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;
  logic   give;

  assign s_tready = (state == ST_IDLE) || (state == ST_LEN) || (state == ST_DATA) ||
                    (state == ST_CKLO) || (state == ST_CKHI);
  assign m_tvalid = state == ST_SEND;
  assign take     = s_tvalid && s_tready;
  assign give     = m_tvalid && m_tready;

  // commands
  assign cmd.load_len  = take && (state == ST_LEN);
  assign cmd.take_data = take && (state == ST_DATA);
  assign cmd.take_cklo = take && (state == ST_CKLO);
  assign cmd.clr_idx   = take && (state == ST_CKHI) && sts.crc_match;
  assign cmd.rd_issue  = state == ST_READ;
  assign cmd.next_idx  = give;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && sts.is_sync) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (take) state_next = ST_DATA;
      end
      ST_DATA: begin
        if (take && sts.data_done) state_next = ST_CKLO;
      end
      ST_CKLO: begin
        if (take) state_next = ST_CKHI;
      end
      ST_CKHI: begin
        if (take) state_next = sts.crc_match ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (give) state_next = sts.last_byte ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mavlink_v1_frame_receiver.sv =====
// MAVLink v1 frame receiver: byte in, checked frame bytes out
// input stream s_*: one received byte per request, tdata = rx_byte
// output stream m_*: one stored frame byte per request of a frame whose checksum matched
// the first byte is offered once the high checksum byte is accepted and a read state
//   has fetched it through the registered read of the frame store
// throughput: 1 input byte per cycle while receiving; each output byte is first fetched
//   by the registered read of the frame store, after the byte before it was taken
// no input is taken while a frame is being emitted; a stalled m_tready holds the
//   current byte and stops the emission, and with it the input side
// bad checksums drop the frame silently and the block goes back to hunting sync
// frames longer than the store keep counting and checksumming; truncated is set
// reset (rst, synchronous) returns to hunting for the 0xFE start mark
// depends on mvr_pkg, mvr_ctrl, mvr_datapath, mvr_ram
`default_nettype none

module mavlink_v1_frame_receiver #(
  parameter int BUFFER_DEPTH = mvr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index,
                                      // [21:14] message_id, [30:22] frame_length, [31] zero
  output logic             m_tuser,   // [0] truncated
  output logic             m_tlast
);

  mvr_pkg::mvr_cmd_t cmd;
  mvr_pkg::mvr_sts_t sts;
  logic [7:0]        frame_byte;
  logic [5:0]        byte_index;
  logic [7:0]        message_id;
  logic [8:0]        frame_length;

  mvr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mvr_datapath #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (s_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .frame_byte  (frame_byte),
    .byte_index  (byte_index),
    .message_id  (message_id),
    .frame_length(frame_length),
    .truncated   (m_tuser),
    .last        (m_tlast)
  );

  // output packing
  assign m_tdata = {1'b0, frame_length, message_id, byte_index, frame_byte};

`ifndef ASSERT_OFF
  // input and output sides never active together
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while emitting");

  // last byte of a frame ends the emission
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("emission continued after last byte");

  // bytes of a frame come out in index order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> ##1
      (m_tvalid && (m_tdata[13:8] == 6'($past(m_tdata[13:8], 2) + 6'd1))))
    else $error("byte index did not advance by one");

  // a new emission starts at index zero
  a_index_start: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid) && $past(s_tready, 2)) |-> (m_tdata[13:8] == 6'd0))
    else $error("frame emission did not start at index zero");
`endif

endmodule

`default_nettype wire
